// ----- src/qmeu_pkg.sv -----
// Package for the queue machine execute unit: sizes, opcodes, payload types,
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qmeu_pkg;
  localparam int QueueDepth = 1024;
  localparam int QAW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int ProgramDepth = 4096;
  localparam int PAW = $clog2(ProgramDepth);
  localparam int NumRegs = 26;
  localparam int WordW = 16;

  localparam logic [4:0] OP_PUSH_IMM = 5'd0;
  localparam logic [4:0] OP_ADD = 5'd1;
  localparam logic [4:0] OP_SUB = 5'd2;
  localparam logic [4:0] OP_MUL = 5'd3;
  localparam logic [4:0] OP_DIV = 5'd4;
  localparam logic [4:0] OP_MOD = 5'd5;
  localparam logic [4:0] OP_POP_REG = 5'd6;
  localparam logic [4:0] OP_PUSH_REG = 5'd7;
  localparam logic [4:0] OP_PRN_Q = 5'd8;
  localparam logic [4:0] OP_PRN_R = 5'd9;
  localparam logic [4:0] OP_PRC_Q = 5'd10;
  localparam logic [4:0] OP_PRC_R = 5'd11;
  localparam logic [4:0] OP_NOP = 5'd12;
  localparam logic [4:0] OP_JMP = 5'd13;
  localparam logic [4:0] OP_JZ = 5'd14;
  localparam logic [4:0] OP_JEQ = 5'd15;
  localparam logic [4:0] OP_JGT = 5'd16;
  localparam logic [4:0] OP_HALT = 5'd17;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;

  typedef struct packed {
    logic [4:0] mode;
    logic [4:0] reg_first;
    logic [4:0] reg_second;
    logic [15:0] immediate;
    logic [11:0] jump_target;
  } instr_t;

  typedef struct packed {
    logic print_valid;
    logic [15:0] print_value;
    logic print_is_char;
    logic branch_taken;
    logic [11:0] branch_address;
    logic halted;
    logic [1:0] status;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch instruction
    logic deq_x;     // pop first operand
    logic deq_y;     // pop second operand
    logic div_start;
    logic div_step;
    logic finish;    // do the write-back and build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- src/qmeu_if.sv -----
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type is a type parameter.
`timescale 1ns / 1ps
`default_nettype none
interface qmeu_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/qmeu_ctrl.sv -----
// Controller FSM of the execute unit: sequences queue reads and the divider.
// Depends on qmeu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qmeu_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [4:0] in_mode,
  input wire logic halted_now,
  output qmeu_pkg::dp_cmd_t cmd,
  input wire qmeu_pkg::dp_sts_t sts,
  output logic out_valid,
  input wire logic out_ready
);
  import qmeu_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_RDX, S_RDY, S_DIV, S_FIN, S_OUT} state_t;
  state_t state;
  logic [4:0] mode;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.deq_x = (state == S_RDX);
    cmd.deq_y = (state == S_RDY);
    cmd.div_start = (state == S_RDY) && (mode == OP_DIV || mode == OP_MOD);
    cmd.div_step = (state == S_DIV);
    cmd.finish = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mode <= OP_NOP;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE, S_OUT: begin
          if (state == S_OUT && out_ready) state <= S_IDLE;
          if (in_valid && in_ready) begin
            mode <= in_mode;
            if (halted_now) state <= S_FIN;
            else if (in_mode inside {[OP_ADD:OP_POP_REG], OP_PRN_Q, OP_PRC_Q})
              state <= S_RDX;
            else state <= S_FIN;
          end
        end
        S_RDX: begin
          if (mode inside {[OP_ADD:OP_MOD]}) state <= S_RDY;
          else state <= S_FIN;
        end
        S_RDY: begin
          if (mode == OP_DIV || mode == OP_MOD) state <= S_DIV;
          else state <= S_FIN;
        end
        S_DIV: if (sts.div_done) state <= S_FIN;
        S_FIN: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/qmeu_dp.sv -----
// Datapath: queue memory, register file, halt flag, serial divider, result reg.
// Depends on qmeu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qmeu_dp (
  input wire logic clk,
  input wire logic rst,
  input wire qmeu_pkg::instr_t in_item,
  input wire qmeu_pkg::dp_cmd_t cmd,
  output qmeu_pkg::dp_sts_t sts,
  output logic halted_now,
  output qmeu_pkg::result_t res
);
  import qmeu_pkg::*;
  logic [WordW-1:0] qmem [QueueDepth];
  logic [WordW-1:0] qrd;
  logic [QAW-1:0] head, tail;
  logic [CntW-1:0] count;
  logic [WordW-1:0] regs [NumRegs];
  logic halt_flag;
  instr_t ins;
  logic [WordW-1:0] x, y;
  logic [1:0] st;
  logic [WordW-1:0] quo, rem;
  logic [4:0] dcnt;
  logic [WordW-1:0] ra, rb, bin, wval;
  logic [WordW+1:0] trial;
  logic is_enq, do_enq, enq_ok;
  logic [QAW-1:0] head_inc, tail_inc, rd_addr;
  result_t res_next;

  assign halted_now = halt_flag;
  assign sts.div_done = (dcnt == 5'd0);
  assign head_inc = (head == QAW'(QueueDepth - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == QAW'(QueueDepth - 1)) ? '0 : tail + 1'b1;
  // a pop moves the read port on to the next word so the second operand is ready
  assign rd_addr = ((cmd.deq_x || cmd.deq_y) && count != '0) ? head_inc : head;

  always_comb begin
    ra = (ins.reg_first < 5'(NumRegs)) ? regs[ins.reg_first] : '0;
    rb = (ins.reg_second < 5'(NumRegs)) ? regs[ins.reg_second] : '0;
    trial = {1'b0, rem, quo[WordW-1]} - {2'b00, y};
    bin = '0;
    case (ins.mode)
      OP_ADD: bin = x + y;
      OP_SUB: bin = x - y;
      OP_MUL: bin = x * y;
      OP_DIV: bin = (y == '0) ? '0 : quo;
      OP_MOD: bin = (y == '0) ? '0 : rem;
      OP_PUSH_REG: bin = ra;
      default: bin = ins.immediate;
    endcase
    wval = bin;
    is_enq = (ins.mode == OP_PUSH_IMM || ins.mode == OP_PUSH_REG ||
              (ins.mode >= OP_ADD && ins.mode <= OP_MOD));
    do_enq = cmd.finish && !halt_flag && is_enq;
    enq_ok = count < CntW'(QueueDepth);
  end

  always_comb begin
    res_next = '0;
    if (halt_flag) begin
      res_next.halted = 1'b1;
    end else begin
      case (ins.mode)
        OP_PRN_Q: begin res_next.print_valid = 1'b1; res_next.print_value = x; end
        OP_PRN_R: begin res_next.print_valid = 1'b1; res_next.print_value = ra; end
        OP_PRC_Q: begin
          res_next.print_valid = 1'b1; res_next.print_is_char = 1'b1;
          res_next.print_value = {8'd0, x[7:0]};
        end
        OP_PRC_R: begin
          res_next.print_valid = 1'b1; res_next.print_is_char = 1'b1;
          res_next.print_value = {8'd0, ra[7:0]};
        end
        OP_JMP: begin
          res_next.branch_taken = 1'b1; res_next.branch_address = ins.jump_target;
        end
        OP_JZ: if (ra == '0) begin
          res_next.branch_taken = 1'b1; res_next.branch_address = ins.jump_target;
        end
        OP_JEQ: if (ra == rb) begin
          res_next.branch_taken = 1'b1; res_next.branch_address = ins.jump_target;
        end
        OP_JGT: if (ra > rb) begin
          res_next.branch_taken = 1'b1; res_next.branch_address = ins.jump_target;
        end
        default: ;
      endcase
      res_next.halted = (ins.mode == OP_HALT);
      if (is_enq && !enq_ok && st == ST_OK) res_next.status = ST_OVER;
      else res_next.status = st;
    end
  end

  // queue memory, registered read
  always_ff @(posedge clk) begin
    qrd <= qmem[rd_addr];
    if (do_enq && enq_ok) qmem[tail] <= wval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; tail <= '0; count <= '0; halt_flag <= 1'b0;
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
      dcnt <= '0;
      res <= '0;
      st <= ST_OK;
    end else begin
      if (cmd.load) begin
        ins <= in_item;
        st <= ST_OK;
        x <= '0; y <= '0;
      end
      // pop: qrd holds the word at head, refreshed on every edge
      if (cmd.deq_x || cmd.deq_y) begin
        if (count == '0) begin
          if (st == ST_OK) st <= ST_UNDER;
        end else begin
          if (cmd.deq_x) x <= qrd; else y <= qrd;
          head <= head_inc;
          count <= count - 1'b1;
        end
      end
      if (cmd.div_start) begin
        quo <= x; rem <= '0; dcnt <= 5'd16;
      end
      if (cmd.div_step && dcnt != 5'd0) begin
        dcnt <= dcnt - 1'b1;
        if (!trial[WordW+1]) begin
          rem <= trial[WordW-1:0];
          quo <= {quo[WordW-2:0], 1'b1};
        end else begin
          rem <= {rem[WordW-2:0], quo[WordW-1]};
          quo <= {quo[WordW-2:0], 1'b0};
        end
      end
      if (cmd.finish) begin
        res <= res_next;
        if (!halt_flag) begin
          if (do_enq) begin
            if (enq_ok) begin
              tail <= tail_inc;
              count <= count + 1'b1;
            end else if (st == ST_OK) st <= ST_OVER;
          end
          if (ins.mode == OP_POP_REG && ins.reg_first < 5'(NumRegs))
            regs[ins.reg_first] <= x;
          if (ins.mode == OP_HALT) halt_flag <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/queue_machine_execute_unit.sv -----
// Execute unit of a 16-bit queue machine: one decoded instruction in on
// channel instr, one result out on channel result (valid/ready, accepted
// when both are high). One item is in flight at a time.
// Sequence after accept: push, register, print, jump and halt go straight
// to the finish state; pop to register and print from queue read one operand
// first; add, sub, mul read two; div and mod read two and then run the
// 16-step restoring divider. A new instruction is accepted in the cycle its
// predecessor's result is taken.
// The queue is a 1024-word memory with a registered read port; each operand
// pop has a state of its own.
// Reset (rst, synchronous) empties the queue, clears the 26 registers and the
// halt flag; no clearing pass is needed. When the receiver stalls, the result
// stays in its register and no new instruction is taken.
// After halt every instruction returns only halted = 1.
// Depends on qmeu_pkg, qmeu_if, qmeu_ctrl, qmeu_dp.
`timescale 1ns / 1ps
`default_nettype none
module queue_machine_execute_unit (
  input wire logic clk,
  input wire logic rst,
  qmeu_if.sink instr,
  qmeu_if.source result
);
  import qmeu_pkg::*;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic halted_now;

  qmeu_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(instr.valid), .in_ready(instr.ready), .in_mode(instr.payload.mode),
    .halted_now(halted_now), .cmd(cmd), .sts(sts),
    .out_valid(result.valid), .out_ready(result.ready)
  );

  qmeu_dp u_dp (
    .clk(clk), .rst(rst), .in_item(instr.payload), .cmd(cmd), .sts(sts),
    .halted_now(halted_now), .res(result.payload)
  );
endmodule
`default_nettype wire

// ----- sim/qmeu_checker.sv -----
// Checker for the queue machine execute unit: watches the instruction and
// result channels, predicts each result and compares. Depends on qmeu_pkg, qmeu_if.
`timescale 1ns / 1ps
module qmeu_checker
  import qmeu_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  qmeu_if.sink instr_mon,
  qmeu_if.sink result_mon,
  input wire logic instr_ready,
  input wire logic result_ready,
  output int fail_count,
  output int pending
);
  logic [15:0] fifo_words[$];
  logic [15:0] regs[NumRegs];
  logic halt_seen;
  result_t expected_q[$];
  logic [1:0] step_st;

  function automatic logic [15:0] reg_rd(logic [4:0] idx);
    return (idx < NumRegs) ? regs[idx] : 16'd0;
  endfunction

  task automatic pull(output logic [15:0] v);
    if (fifo_words.size() == 0) begin
      if (step_st == ST_OK) step_st = ST_UNDER;
      v = 16'd0;
    end else v = fifo_words.pop_front();
  endtask

  task automatic push_word(logic [15:0] v);
    if (fifo_words.size() >= QueueDepth) begin
      if (step_st == ST_OK) step_st = ST_OVER;
    end else fifo_words.push_back(v);
  endtask

  task automatic execute(instr_t ins);
    result_t r;
    logic [15:0] x, y;
    r = '0;
    step_st = ST_OK;
    if (!halt_seen) begin
      case (ins.mode)
        OP_PUSH_IMM: push_word(ins.immediate);
        OP_ADD: begin pull(x); pull(y); push_word(x + y); end
        OP_SUB: begin pull(x); pull(y); push_word(x - y); end
        OP_MUL: begin pull(x); pull(y); push_word(x * y); end
        OP_DIV: begin pull(x); pull(y); push_word(y == 16'd0 ? 16'd0 : x / y); end
        OP_MOD: begin pull(x); pull(y); push_word(y == 16'd0 ? 16'd0 : x % y); end
        OP_POP_REG: begin
          pull(x);
          if (ins.reg_first < NumRegs) regs[ins.reg_first] = x;
        end
        OP_PUSH_REG: push_word(reg_rd(ins.reg_first));
        OP_PRN_Q: begin r.print_valid = 1'b1; pull(x); r.print_value = x; end
        OP_PRN_R: begin r.print_valid = 1'b1; r.print_value = reg_rd(ins.reg_first); end
        OP_PRC_Q: begin
          r.print_valid = 1'b1; r.print_is_char = 1'b1; pull(x);
          r.print_value = {8'd0, x[7:0]};
        end
        OP_PRC_R: begin
          r.print_valid = 1'b1; r.print_is_char = 1'b1;
          x = reg_rd(ins.reg_first);
          r.print_value = {8'd0, x[7:0]};
        end
        OP_JMP: r.branch_taken = 1'b1;
        OP_JZ: r.branch_taken = reg_rd(ins.reg_first) == 16'd0;
        OP_JEQ: r.branch_taken = reg_rd(ins.reg_first) == reg_rd(ins.reg_second);
        OP_JGT: r.branch_taken = reg_rd(ins.reg_first) > reg_rd(ins.reg_second);
        OP_HALT: halt_seen = 1'b1;
        default: ;
      endcase
    end
    if (r.branch_taken) r.branch_address = ins.jump_target;
    r.halted = halt_seen;
    r.status = step_st;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      fifo_words.delete();
      expected_q.delete();
      foreach (regs[i]) regs[i] = 16'd0;
      halt_seen = 1'b0;
      fail_count = 0;
      pending = 0;
    end else begin
      if (result_mon.valid && result_ready) begin
        got = result_mon.payload;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fail_count++;
          end
        end
      end
      if (instr_mon.valid && instr_ready) execute(instr_mon.payload);
      pending = expected_q.size();
    end
  end
endmodule

// ----- sim/tb_queue_machine_execute_unit.sv -----
// Testbench top for the queue machine execute unit: clock, reset, instruction
// stimulus, result back-pressure and verdict. Depends on qmeu_pkg, qmeu_if,
// qmeu_checker and the block.
`timescale 1ns / 1ps
module tb_queue_machine_execute_unit;
  import qmeu_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int fail_count, pending;
  int cycle_count = 0;
  bit stall_long = 0;
  bit stim_done = 0;

  qmeu_if #(.T(instr_t)) instr_ch (clk);
  qmeu_if #(.T(result_t)) result_ch (clk);

  queue_machine_execute_unit dut (.clk(clk), .rst(rst), .instr(instr_ch), .result(result_ch));

  qmeu_checker chk (
    .clk(clk), .rst(rst), .instr_mon(instr_ch), .result_mon(result_ch),
    .instr_ready(instr_ch.ready), .result_ready(result_ch.ready),
    .fail_count(fail_count), .pending(pending));

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random 0..3 waits per item, long hold-off on request
  initial begin
    int w;
    result_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (stall_long) begin
        result_ch.ready <= 0;
        repeat (400) @(negedge clk);
        stall_long = 0;
      end
      w = $urandom_range(0, 3);
      if (w > 0) begin
        result_ch.ready <= 0;
        repeat (w - 1) @(negedge clk);
        @(negedge clk);
      end
      result_ch.ready <= 1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  // valid stays high after an accept; the next send or drain decides its value
  task automatic send(instr_t ins, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 3) : 0;
    if (w > 0) begin
      instr_ch.valid <= 0;
      repeat (w) @(negedge clk);
    end
    instr_ch.payload <= ins;
    instr_ch.valid <= 1;
    do @(posedge clk); while (!instr_ch.ready);
    @(negedge clk);
  endtask

  function automatic instr_t mk(logic [4:0] m, logic [15:0] imm);
    instr_t i;
    i.mode = m;
    i.reg_first = 5'($urandom_range(0, 31));
    i.reg_second = 5'($urandom_range(0, 31));
    i.immediate = imm;
    i.jump_target = 12'($urandom);
    return i;
  endfunction

  function automatic instr_t rand_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) return mk(OP_PUSH_IMM, (k < 5) ? 16'd0 : 16'($urandom));
    if (k < 45) return mk(5'($urandom_range(OP_ADD, OP_MOD)), 16'd0);
    if (k < 97) return mk(5'($urandom_range(OP_POP_REG, OP_JGT)), 16'($urandom));
    return mk(5'($urandom_range(18, 31)), 16'($urandom));
  endfunction

  task automatic drain();
    instr_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    instr_t ins;
    instr_ch.valid = 0;
    instr_ch.payload = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: underflow, extremes, each op but push from register and halt, an unused opcode, divide by zero
    send(mk(OP_ADD, 16'd0), 1'b1);
    send(mk(OP_PRN_Q, 16'd0), 1'b1);
    send(mk(OP_PUSH_IMM, 16'hFFFF), 1'b1);
    send(mk(OP_PUSH_IMM, 16'hFFFF), 1'b1);
    send(mk(OP_MUL, 16'd0), 1'b1);
    send(mk(OP_PUSH_IMM, 16'd0), 1'b1);
    send(mk(OP_DIV, 16'd0), 1'b1);
    send(mk(OP_PUSH_IMM, 16'd0), 1'b1);
    send(mk(OP_MOD, 16'd0), 1'b1);
    send(mk(OP_PUSH_IMM, 16'd7), 1'b1);
    send(mk(OP_PUSH_IMM, 16'd300), 1'b1);
    send(mk(OP_SUB, 16'd0), 1'b1);
    ins = mk(OP_POP_REG, 16'd0); ins.reg_first = 5'd25; send(ins, 1'b1);
    ins = mk(OP_PRC_R, 16'd0); ins.reg_first = 5'd25; send(ins, 1'b1);
    ins = mk(OP_PRN_R, 16'd0); ins.reg_first = 5'd31; send(ins, 1'b1);
    ins = mk(OP_JGT, 16'd0); ins.reg_first = 5'd25; ins.reg_second = 5'd0;
    ins.jump_target = 12'hFFF; send(ins, 1'b1);
    ins = mk(OP_JEQ, 16'd0); ins.reg_first = 5'd0; ins.reg_second = 5'd30;
    send(ins, 1'b1);
    send(mk(OP_JZ, 16'd0), 1'b1);
    send(mk(OP_JMP, 16'd0), 1'b1);
    send(mk(OP_NOP, 16'd0), 1'b1);
    send(mk(OP_PRC_Q, 16'd0), 1'b1);
    send(mk(5'd31, 16'd0), 1'b1);
    // sender pause until all results are back
    drain();
    // long receiver hold-off while the sender keeps offering items
    stall_long = 1;
    for (int n = 0; n < 720; n++) send(rand_item(), ($urandom_range(0, 3) != 0));
    drain();
    send(mk(OP_HALT, 16'd0), 1'b1);
    for (int n = 0; n < 8; n++) send(rand_item(), 1'b1);
    drain();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
